// ----- hw/rtl/qcq_pkg.sv -----
// qcq_pkg: shared constants and control/status types of the quartile color quantizer.
// No dependencies.
`default_nettype none

package qcq_pkg;

    localparam int MAX_PIXELS_DEF = 131072;
    localparam int NUM_LEVELS     = 4;
    localparam int COLOR_SPAN     = 256;
    localparam int NUM_CHANNELS   = 3;
    localparam int NUM_BINS       = NUM_CHANNELS * NUM_LEVELS;
    localparam int PIX_CNT_W      = 18;
    localparam int COLOR_W        = 8;
    localparam int BIN_IDX_W      = 4;
    localparam int DIV_STEPS      = 8;

    localparam logic [PIX_CNT_W-1:0] PIX_CNT_RST = PIX_CNT_W'(104500);
    localparam logic [BIN_IDX_W-1:0] LAST_BIN    = BIN_IDX_W'(NUM_BINS - 1);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic                 load;
        logic                 hist_wb;
        logic                 clr;
        logic                 walk;
        logic                 bin;
        logic                 div_start;
        logic                 rd_empty;
        logic                 rd_issue;
        logic                 rd_out;
        logic [BIN_IDX_W-1:0] bidx;
    } qcq_cmd_t;

    typedef struct packed {
        logic last_load;
        logic sweep_last;
        logic walk_done;
        logic bin_done;
        logic div_done;
        logic reading;
        logic out_full;
    } qcq_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/quartile_color_quantizer.sv -----
// Quartile color quantizer: loads an RGB frame, finds per-channel quartile bins,
// and reads back pixels mapped to bin means.
// Depends on qcq_pkg, qcq_ctrl, qcq_dp (qcq_ram, qcq_div).
//
// Input channel (s_*): s_mode 0 loads one pixel, s_mode 1 requests the next quantized
// pixel. A load makes no transfer on the m_* channel; every read makes exactly one.
// A load is a histogram read-modify-write (read on accept, write back in ST_LD_WB).
// The last load of a frame (pixel_count pixels, clamped to 1..MAX_PIXELS) then runs
// the processing: threshold walk, bin pass and level division of all 12 bins;
// s_ready is low meanwhile. A read does a label store read, then a level lookup into
// the output register; a read with no completed frame answers with m_status 1. A read
// is taken only when the output register is free, so a new read waits until the last
// result is taken; loads are taken while a result waits. When the receiver stalls
// the result holds in the output register.
// After reset all 256 histogram entries are cleared with s_ready low;
// cfg_wr_en writes pixel_count at any time the block is idle.
`default_nettype none

module quartile_color_quantizer #(
    parameter int MAX_PIXELS = qcq_pkg::MAX_PIXELS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [qcq_pkg::PIX_CNT_W-1:0] cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_mode,
    input  wire logic [7:0]                    s_red_in,
    input  wire logic [7:0]                    s_green_in,
    input  wire logic [7:0]                    s_blue_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_red_out,
    output logic [7:0]                         m_green_out,
    output logic [7:0]                         m_blue_out,
    output logic                               m_last_pixel,
    output logic                               m_status
);

    qcq_pkg::qcq_cmd_t  cmd;
    qcq_pkg::qcq_stat_t st;

    qcq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .st      (st),
        .cmd     (cmd)
    );

    qcq_dp #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .cmd          (cmd),
        .st           (st),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_last_pixel (m_last_pixel),
        .m_status     (m_status)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/qcq_ram.sv -----
// qcq_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none

module qcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/qcq_div.sv -----
// qcq_div: restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on qcq_pkg.
`default_nettype none

module qcq_div #(
    parameter int SUM_W = 26,
    parameter int CNT_W = 18
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [SUM_W-1:0]              dividend,
    input  wire logic [CNT_W-1:0]              divisor,
    output logic                               done,
    output logic [qcq_pkg::COLOR_W-1:0]        quo
);

    localparam int STEP_W = $clog2(qcq_pkg::DIV_STEPS);

    logic [SUM_W-1:0]            rem_reg;
    logic [SUM_W-1:0]            dsh_reg;
    logic [qcq_pkg::COLOR_W-1:0] q_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic                        ge;

    assign ge   = rem_reg >= dsh_reg;
    assign done = done_reg;
    assign quo  = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(qcq_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsh_reg <= SUM_W'(divisor) << (qcq_pkg::DIV_STEPS - 1);
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_reg - dsh_reg : rem_reg;
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[qcq_pkg::COLOR_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/qcq_dp.sv -----
// qcq_dp: datapath - frame, label and histogram stores, threshold walk, bin pass,
// level table and output register. Depends on qcq_pkg, qcq_ram, qcq_div.
`default_nettype none

module qcq_dp #(
    parameter int MAX_PIXELS = qcq_pkg::MAX_PIXELS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [qcq_pkg::PIX_CNT_W-1:0]   cfg_wr_data,
    input  wire logic [7:0]                      s_red_in,
    input  wire logic [7:0]                      s_green_in,
    input  wire logic [7:0]                      s_blue_in,
    input  wire qcq_pkg::qcq_cmd_t               cmd,
    output qcq_pkg::qcq_stat_t                   st,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [7:0]                           m_red_out,
    output logic [7:0]                           m_green_out,
    output logic [7:0]                           m_blue_out,
    output logic                                 m_last_pixel,
    output logic                                 m_status
);

    localparam int IDX_W = $clog2(MAX_PIXELS);
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W = CNT_W + qcq_pkg::COLOR_W;
    localparam int NCH   = qcq_pkg::NUM_CHANNELS;
    localparam int NLV   = qcq_pkg::NUM_LEVELS;
    localparam int HA_W  = $clog2(qcq_pkg::COLOR_SPAN);
    localparam int PIX_W = NCH * qcq_pkg::COLOR_W;
    localparam int LBL_W = NCH * 2;

    logic [qcq_pkg::PIX_CNT_W-1:0] pix_cnt_reg;
    logic                          reading_reg;
    logic [IDX_W-1:0]              load_idx_reg;
    logic [IDX_W-1:0]              read_idx_reg;
    logic [CNT_W-1:0]              frame_len_reg;
    logic [8:0]                    sweep_reg;
    logic [CNT_W-1:0]              pidx_reg;
    logic                          vd_reg;
    logic                          m_valid_reg;

    logic [7:0]       lat_reg [NCH];
    logic [IDX_W-1:0] idx_lat_reg;
    logic [HA_W-1:0]  haddr_d_reg;
    logic [IDX_W-1:0] addr_d_reg;
    logic [CNT_W-1:0] run_reg   [NCH];
    logic [1:0]       found_reg [NCH];
    logic [7:0]       thr_reg   [NCH][3];
    logic [CNT_W-1:0] cnt_reg   [NCH][NLV];
    logic [SUM_W-1:0] sum_reg   [NCH][NLV];
    logic [7:0]       lvl_reg   [NCH][NLV];
    logic [qcq_pkg::BIN_IDX_W-1:0] lvl_idx_reg;
    logic             lvl_zero_reg;
    logic [7:0]       m_red_reg, m_green_reg, m_blue_reg;
    logic             m_last_reg, m_status_reg;

    logic [CNT_W-1:0] eff_count;
    logic [CNT_W-1:0] quarter;
    logic [IDX_W-1:0] load_addr;
    logic             last_load;
    logic             rd_last;
    logic [7:0]       in_pix [NCH];
    logic [HA_W-1:0]  hist_raddr [NCH];
    logic [HA_W-1:0]  hist_waddr [NCH];
    logic [CNT_W-1:0] hist_wdata [NCH];
    logic [CNT_W-1:0] hist_rdata [NCH];
    logic             hist_we;
    logic [PIX_W-1:0] frm_rdata;
    logic [LBL_W-1:0] lbl_rdata;
    logic [LBL_W-1:0] lbl_wdata;
    logic [7:0]       lv   [NCH];
    logic [1:0]       bsel [NCH];
    logic [CNT_W-1:0] wsum [NCH];
    logic             wge  [NCH];
    logic [CNT_W-1:0] cnt_sel;
    logic [SUM_W-1:0] sum_sel;
    logic             div_done;
    logic [7:0]       div_quo;

    assign in_pix[0] = s_red_in;
    assign in_pix[1] = s_green_in;
    assign in_pix[2] = s_blue_in;

    always_comb begin
        if (pix_cnt_reg == '0) begin
            eff_count = CNT_W'(1);
        end else if (32'(pix_cnt_reg) > 32'(MAX_PIXELS)) begin
            eff_count = CNT_W'(MAX_PIXELS);
        end else begin
            eff_count = CNT_W'(pix_cnt_reg);
        end
    end

    assign quarter   = frame_len_reg >> 2;
    assign load_addr = reading_reg ? '0 : load_idx_reg;
    assign last_load = (CNT_W'(idx_lat_reg) + CNT_W'(1)) >= eff_count;
    assign rd_last   = (CNT_W'(read_idx_reg) + CNT_W'(1)) >= frame_len_reg;

    // histogram: one store per channel
    assign hist_we = cmd.clr | (cmd.walk & vd_reg) | cmd.hist_wb;

    for (genvar c = 0; c < NCH; c++) begin : g_hist
        assign hist_raddr[c] = cmd.walk ? sweep_reg[HA_W-1:0] : in_pix[c];
        assign hist_waddr[c] = cmd.clr  ? sweep_reg[HA_W-1:0] :
                               cmd.walk ? haddr_d_reg : lat_reg[c];
        assign hist_wdata[c] = cmd.hist_wb ? hist_rdata[c] + CNT_W'(1) : '0;

        qcq_ram #(.WIDTH(CNT_W), .DEPTH(qcq_pkg::COLOR_SPAN)) u_hist (
            .aclk  (aclk),
            .we    (hist_we),
            .waddr (hist_waddr[c]),
            .wdata (hist_wdata[c]),
            .raddr (hist_raddr[c]),
            .rdata (hist_rdata[c])
        );
    end

    qcq_ram #(.WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_frame (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (load_addr),
        .wdata ({s_red_in, s_green_in, s_blue_in}),
        .raddr (pidx_reg[IDX_W-1:0]),
        .rdata (frm_rdata)
    );

    qcq_ram #(.WIDTH(LBL_W), .DEPTH(MAX_PIXELS)) u_label (
        .aclk  (aclk),
        .we    (cmd.bin & vd_reg),
        .waddr (addr_d_reg),
        .wdata (lbl_wdata),
        .raddr (read_idx_reg),
        .rdata (lbl_rdata)
    );

    // threshold walk and bin chain, per channel
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            wsum[c] = run_reg[c] + hist_rdata[c];
            wge[c]  = wsum[c] >= quarter;
            lv[c]   = frm_rdata[PIX_W-1-8*c -: 8];
            if (lv[c] <= thr_reg[c][0] && cnt_reg[c][0] < quarter) begin
                bsel[c] = 2'd0;
            end else if (lv[c] >= thr_reg[c][0] && lv[c] <= thr_reg[c][1]
                         && cnt_reg[c][1] < quarter) begin
                bsel[c] = 2'd1;
            end else if (lv[c] >= thr_reg[c][1] && lv[c] <= thr_reg[c][2]
                         && cnt_reg[c][2] < quarter) begin
                bsel[c] = 2'd2;
            end else begin
                bsel[c] = 2'd3;
            end
        end
        lbl_wdata = {bsel[2], bsel[1], bsel[0]};
    end

    assign cnt_sel = cnt_reg[cmd.bidx[3:2]][cmd.bidx[1:0]];
    assign sum_sel = sum_reg[cmd.bidx[3:2]][cmd.bidx[1:0]];

    qcq_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_sel + SUM_W'(cnt_sel >> 1)),
        .divisor  (cnt_sel),
        .done     (div_done),
        .quo      (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_cnt_reg   <= qcq_pkg::PIX_CNT_RST;
            reading_reg   <= 1'b0;
            load_idx_reg  <= '0;
            read_idx_reg  <= '0;
            frame_len_reg <= '0;
            sweep_reg     <= '0;
            pidx_reg      <= '0;
            vd_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pix_cnt_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                reading_reg <= 1'b0;
            end
            if (cmd.hist_wb) begin
                if (last_load) begin
                    frame_len_reg <= CNT_W'(idx_lat_reg) + CNT_W'(1);
                    load_idx_reg  <= '0;
                    read_idx_reg  <= '0;
                    reading_reg   <= 1'b1;
                    sweep_reg     <= '0;
                    vd_reg        <= 1'b0;
                end else begin
                    load_idx_reg <= idx_lat_reg + IDX_W'(1);
                end
            end
            if (cmd.clr) begin
                sweep_reg <= (sweep_reg[HA_W-1:0] == '1) ? '0 : sweep_reg + 9'd1;
            end
            if (cmd.walk) begin
                if (!sweep_reg[HA_W]) begin
                    sweep_reg <= sweep_reg + 9'd1;
                    vd_reg    <= 1'b1;
                end else begin
                    vd_reg   <= 1'b0;
                    pidx_reg <= '0;
                end
            end
            if (cmd.bin) begin
                if (pidx_reg != frame_len_reg) begin
                    pidx_reg <= pidx_reg + CNT_W'(1);
                    vd_reg   <= 1'b1;
                end else begin
                    vd_reg <= 1'b0;
                end
            end
            if (cmd.rd_out) begin
                if (rd_last) begin
                    reading_reg  <= 1'b0;
                    read_idx_reg <= '0;
                    load_idx_reg <= '0;
                end else begin
                    read_idx_reg <= read_idx_reg + IDX_W'(1);
                end
            end
            if (cmd.rd_empty | cmd.rd_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int c = 0; c < NCH; c++) begin
                lat_reg[c] <= in_pix[c];
            end
            idx_lat_reg <= load_addr;
        end
        if (cmd.hist_wb && last_load) begin
            for (int c = 0; c < NCH; c++) begin
                run_reg[c]   <= '0;
                found_reg[c] <= 2'd0;
                for (int k = 0; k < 3; k++) begin
                    thr_reg[c][k] <= 8'hFF;
                end
            end
        end
        if (cmd.walk) begin
            haddr_d_reg <= sweep_reg[HA_W-1:0];
            if (vd_reg) begin
                for (int c = 0; c < NCH; c++) begin
                    if (wge[c]) begin
                        if (found_reg[c] != 2'd3) begin
                            thr_reg[c][found_reg[c]] <= haddr_d_reg;
                            found_reg[c] <= found_reg[c] + 2'd1;
                        end
                        run_reg[c] <= wsum[c] - quarter;
                    end else begin
                        run_reg[c] <= wsum[c];
                    end
                end
            end
            if (sweep_reg[HA_W]) begin
                for (int c = 0; c < NCH; c++) begin
                    for (int k = 0; k < NLV; k++) begin
                        cnt_reg[c][k] <= '0;
                        sum_reg[c][k] <= '0;
                    end
                end
            end
        end
        if (cmd.bin) begin
            addr_d_reg <= pidx_reg[IDX_W-1:0];
            if (vd_reg) begin
                for (int c = 0; c < NCH; c++) begin
                    cnt_reg[c][bsel[c]] <= cnt_reg[c][bsel[c]] + CNT_W'(1);
                    sum_reg[c][bsel[c]] <= sum_reg[c][bsel[c]] + SUM_W'(lv[c]);
                end
            end
        end
        if (cmd.div_start) begin
            lvl_idx_reg  <= cmd.bidx;
            lvl_zero_reg <= cnt_sel == '0;
        end
        if (div_done) begin
            lvl_reg[lvl_idx_reg[3:2]][lvl_idx_reg[1:0]] <= lvl_zero_reg ? 8'd0 : div_quo;
        end
        if (cmd.rd_empty) begin
            m_red_reg    <= 8'd0;
            m_green_reg  <= 8'd0;
            m_blue_reg   <= 8'd0;
            m_last_reg   <= 1'b0;
            m_status_reg <= 1'b1;
        end else if (cmd.rd_out) begin
            m_red_reg    <= lvl_reg[0][lbl_rdata[1:0]];
            m_green_reg  <= lvl_reg[1][lbl_rdata[3:2]];
            m_blue_reg   <= lvl_reg[2][lbl_rdata[5:4]];
            m_last_reg   <= rd_last;
            m_status_reg <= 1'b0;
        end
    end

    assign st.last_load  = last_load;
    assign st.sweep_last = sweep_reg[HA_W-1:0] == '1;
    assign st.walk_done  = sweep_reg[HA_W];
    assign st.bin_done   = pidx_reg == frame_len_reg;
    assign st.div_done   = div_done;
    assign st.reading    = reading_reg;
    assign st.out_full   = m_valid_reg;

    assign m_valid      = m_valid_reg;
    assign m_red_out    = m_red_reg;
    assign m_green_out  = m_green_reg;
    assign m_blue_out   = m_blue_reg;
    assign m_last_pixel = m_last_reg;
    assign m_status     = m_status_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/qcq_ctrl.sv -----
// qcq_ctrl: controller state machine; sequences load, clear, walk, bin pass,
// level division and readout. Depends on qcq_pkg.
`default_nettype none

module qcq_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_mode,
    input  wire qcq_pkg::qcq_stat_t  st,
    output qcq_pkg::qcq_cmd_t        cmd
);

    localparam logic [2:0] ST_CLR      = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_LD_WB    = 3'd2;
    localparam logic [2:0] ST_WALK     = 3'd3;
    localparam logic [2:0] ST_BIN      = 3'd4;
    localparam logic [2:0] ST_DIV_GO   = 3'd5;
    localparam logic [2:0] ST_DIV_WAIT = 3'd6;
    localparam logic [2:0] ST_RD_WAIT  = 3'd7;

    logic [2:0]                      state_reg, state_next;
    logic [qcq_pkg::BIN_IDX_W-1:0]   bidx_reg, bidx_next;

    always_comb begin
        state_next = state_reg;
        bidx_next  = bidx_reg;
        cmd        = '0;
        cmd.bidx   = bidx_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLR: begin
                cmd.clr = 1'b1;
                if (st.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = (s_mode == qcq_pkg::MODE_LOAD) || !st.out_full;
                if (s_valid && s_ready) begin
                    if (s_mode == qcq_pkg::MODE_LOAD) begin
                        cmd.load   = 1'b1;
                        state_next = ST_LD_WB;
                    end else if (st.reading) begin
                        cmd.rd_issue = 1'b1;
                        state_next   = ST_RD_WAIT;
                    end else begin
                        cmd.rd_empty = 1'b1;
                    end
                end
            end
            ST_LD_WB: begin
                cmd.hist_wb = 1'b1;
                state_next  = st.last_load ? ST_WALK : ST_IDLE;
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (st.walk_done) begin
                    state_next = ST_BIN;
                end
            end
            ST_BIN: begin
                cmd.bin = 1'b1;
                if (st.bin_done) begin
                    state_next = ST_DIV_GO;
                    bidx_next  = '0;
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (st.div_done) begin
                    if (bidx_reg == qcq_pkg::LAST_BIN) begin
                        state_next = ST_IDLE;
                    end else begin
                        bidx_next  = bidx_reg + 4'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_RD_WAIT: begin
                cmd.rd_out = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            bidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            bidx_reg  <= bidx_next;
        end
    end

    a_rd_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> !st.out_full)
        else $error("label read issued while output register full");

    a_ld_return: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LD_WB && !st.last_load) |=> state_reg == ST_IDLE)
        else $error("load did not return to idle");

    a_walk_to_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.walk && st.walk_done) |=> (state_reg == ST_BIN && st.reading))
        else $error("walk did not hand over to bin pass");

    a_frame_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_WAIT && st.div_done && bidx_reg == qcq_pkg::LAST_BIN)
        |=> (state_reg == ST_IDLE && st.reading))
        else $error("levels done but frame not readable");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: self-checking testbench for quartile_color_quantizer.
// Drives pixel loads and reads over valid/ready, predicts each quantized pixel in place.
// Depends on qcq_pkg and the quartile_color_quantizer RTL.
`timescale 1ns / 100ps

module tb;

    localparam int MAXPIX    = qcq_pkg::MAX_PIXELS_DEF;
    localparam int IDLE_WAIT = 1000;
    localparam int WD_LIMIT  = 20000;

    typedef struct {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit       last;
        bit       status;
    } qpix_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [qcq_pkg::PIX_CNT_W-1:0] cfg_wr_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_mode = 1'b0;
    logic [7:0]                    s_red_in = '0;
    logic [7:0]                    s_green_in = '0;
    logic [7:0]                    s_blue_in = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [7:0]                    m_red_out;
    logic [7:0]                    m_green_out;
    logic [7:0]                    m_blue_out;
    logic                          m_last_pixel;
    logic                          m_status;

    quartile_color_quantizer u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_last_pixel (m_last_pixel),
        .m_status     (m_status)
    );

    // quantizer shadow state
    bit [23:0]   pix_mem [0:MAXPIX-1];
    bit [5:0]    lbl_mem [0:MAXPIX-1];
    int unsigned hist_m [0:3*qcq_pkg::COLOR_SPAN-1];
    int unsigned thr_m [0:8];
    int unsigned bcnt_m [0:qcq_pkg::NUM_BINS-1];
    longint unsigned bsum_m [0:qcq_pkg::NUM_BINS-1];
    bit [7:0]    lvl_m [0:qcq_pkg::NUM_BINS-1];
    int unsigned ld_idx, rd_idx, frm_len, cnt_reg;
    bit          reading;

    qpix_t pending_pix[$];
    int    errors = 0;
    int    n_items = 0, n_results = 0, n_frames = 0;
    int    tx_idle_pct = 0, rx_idle_pct = 0;
    int    hold_req = 0, hold_seen = 0, hold_cnt = 0;
    int    quiet_cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned eff_count();
        int unsigned c;
        c = cnt_reg;
        if (c == 0) c = 1;
        if (c > MAXPIX) c = MAXPIX;
        return c;
    endfunction

    function automatic void build_levels(input int unsigned count);
        int unsigned quarter, run, found, lv, t0, t1, t2, b, n;
        bit [5:0] lbl;
        quarter = count / 4;
        for (int ch = 0; ch < 3; ch++) begin
            run = 0;
            found = 0;
            for (int k = 0; k < 3; k++) thr_m[ch*3+k] = 255;
            for (int v = 0; v < qcq_pkg::COLOR_SPAN; v++) begin
                run += hist_m[ch*qcq_pkg::COLOR_SPAN+v];
                if (run >= quarter) begin
                    if (found < 3) begin
                        thr_m[ch*3+found] = v;
                        found++;
                    end
                    run -= quarter;
                end
            end
        end
        for (int i = 0; i < qcq_pkg::NUM_BINS; i++) begin
            bcnt_m[i] = 0;
            bsum_m[i] = 0;
        end
        for (int p = 0; p < count && p < MAXPIX; p++) begin
            lbl = '0;
            for (int ch = 0; ch < 3; ch++) begin
                lv = (pix_mem[p] >> (16 - 8*ch)) & 8'hFF;
                t0 = thr_m[ch*3];
                t1 = thr_m[ch*3+1];
                t2 = thr_m[ch*3+2];
                if (lv <= t0 && bcnt_m[ch*4] < quarter) b = 0;
                else if (lv >= t0 && lv <= t1 && bcnt_m[ch*4+1] < quarter) b = 1;
                else if (lv >= t1 && lv <= t2 && bcnt_m[ch*4+2] < quarter) b = 2;
                else b = 3;
                bcnt_m[ch*4+b]++;
                bsum_m[ch*4+b] += lv;
                lbl[2*ch +: 2] = b[1:0];
            end
            lbl_mem[p] = lbl;
        end
        for (int i = 0; i < qcq_pkg::NUM_BINS; i++) begin
            n = bcnt_m[i];
            lvl_m[i] = n ? 8'((bsum_m[i] + n/2) / n) : 8'd0;
        end
    endfunction

    function automatic void model_item(input bit mode, input bit [7:0] r, g, b);
        int unsigned count;
        qpix_t q;
        bit [5:0] lbl;
        if (mode == qcq_pkg::MODE_LOAD) begin
            count = eff_count();
            if (reading) begin
                reading = 1'b0;
                ld_idx = 0;
            end
            if (ld_idx >= MAXPIX) ld_idx = 0;
            if (ld_idx == 0) foreach (hist_m[i]) hist_m[i] = 0;
            pix_mem[ld_idx] = {r, g, b};
            hist_m[r]++;
            hist_m[qcq_pkg::COLOR_SPAN+g]++;
            hist_m[2*qcq_pkg::COLOR_SPAN+b]++;
            if (ld_idx + 1 >= count) begin
                frm_len = ld_idx + 1;
                build_levels(frm_len);
                reading = 1'b1;
                rd_idx = 0;
                ld_idx = 0;
                n_frames++;
            end else begin
                ld_idx++;
            end
            return;
        end
        q = '{default: 0};
        if (!reading || rd_idx >= frm_len || rd_idx >= MAXPIX) begin
            q.status = 1'b1;
        end else begin
            lbl = lbl_mem[rd_idx];
            q.red   = lvl_m[lbl[1:0]];
            q.green = lvl_m[4 + lbl[3:2]];
            q.blue  = lvl_m[8 + lbl[5:4]];
            if (rd_idx + 1 >= frm_len) begin
                q.last = 1'b1;
                reading = 1'b0;
                rd_idx = 0;
                ld_idx = 0;
            end else begin
                rd_idx++;
            end
        end
        pending_pix.push_back(q);
    endfunction

    task automatic send_item(input bit mode, input bit [7:0] r, g, b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        do @(posedge aclk); while (!s_ready);
        model_item(mode, r, g, b);
        n_items++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pix.size() != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_count(input int unsigned v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= qcq_pkg::PIX_CNT_W'(v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cnt_reg = v & 32'h3FFFF;
    endtask

    task automatic load_pixels(input int n, input int style);
        bit [7:0] base, c [3];
        base = 8'($urandom);
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 3; k++) begin
                case (style)
                    0: c[k] = 8'($urandom);
                    1: c[k] = base + 8'($urandom_range(7));
                    default: begin
                        case ($urandom_range(2))
                            0: c[k] = 8'd0;
                            1: c[k] = 8'd255;
                            default: c[k] = base;
                        endcase
                    end
                endcase
            end
            if ($urandom_range(9) == 0) begin
                send_item(qcq_pkg::MODE_READ, 8'($urandom), 8'($urandom), 8'd0);
            end
            send_item(qcq_pkg::MODE_LOAD, c[0], c[1], c[2]);
        end
    endtask

    task automatic read_pixels(input int n);
        for (int i = 0; i < n; i++) begin
            send_item(qcq_pkg::MODE_READ, 8'($urandom), 8'($urandom), 8'd0);
        end
    endtask

    task automatic test_extremes();
        write_count(4);
        read_pixels(1);
        send_item(qcq_pkg::MODE_LOAD, 8'd0, 8'd0, 8'd0);
        send_item(qcq_pkg::MODE_LOAD, 8'd255, 8'd255, 8'd255);
        send_item(qcq_pkg::MODE_LOAD, 8'd0, 8'd255, 8'd128);
        send_item(qcq_pkg::MODE_LOAD, 8'd255, 8'd0, 8'd1);
        read_pixels(5);
    endtask

    task automatic test_small_counts();
        write_count(0);
        send_item(qcq_pkg::MODE_LOAD, 8'd77, 8'd200, 8'd3);
        read_pixels(2);
        write_count(3);
        load_pixels(3, 0);
        read_pixels(4);
    endtask

    task automatic test_count_change();
        write_count(262143);
        load_pixels(5, 0);
        write_count(5);
        send_item(qcq_pkg::MODE_LOAD, 8'd9, 8'd99, 8'd199);
        read_pixels(3);
        write_count(MAXPIX);
        load_pixels(2, 2);
        write_count(4);
        load_pixels(2, 1);
        read_pixels(5);
    endtask

    task automatic test_abandon();
        write_count(6);
        load_pixels(6, 0);
        read_pixels(2);
        load_pixels(6, 2);
        read_pixels(7);
    endtask

    task automatic test_backpressure();
        write_count(8);
        load_pixels(8, 0);
        hold_req++;
        read_pixels(12);
    endtask

    task automatic test_random(input int target);
        int stop_at, cnt, style, nrd;
        stop_at = n_items + target;
        while (n_items < stop_at) begin
            cnt = ($urandom_range(7) == 0) ? $urandom_range(3) : $urandom_range(4, 48);
            write_count(cnt);
            repeat ($urandom_range(1, 4)) begin
                style = $urandom_range(2);
                load_pixels(eff_count(), style);
                if ($urandom_range(7) == 0) nrd = $urandom_range(eff_count() - 1);
                else nrd = eff_count() + $urandom_range(2);
                read_pixels(nrd);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt  <= 400;
            m_ready   <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        qpix_t q;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_pix.size() == 0) begin
                $display("%0t: unexpected transfer r=%0d g=%0d b=%0d last=%0d st=%0d", $time,
                         m_red_out, m_green_out, m_blue_out, m_last_pixel, m_status);
                errors++;
            end else begin
                q = pending_pix.pop_front();
                if (m_red_out !== q.red || m_green_out !== q.green || m_blue_out !== q.blue
                    || m_last_pixel !== q.last || m_status !== q.status) begin
                    $display("%0t: mismatch exp r=%0d g=%0d b=%0d last=%0d st=%0d", $time,
                             q.red, q.green, q.blue, q.last, q.status);
                    $display("%0t:          got r=%0d g=%0d b=%0d last=%0d st=%0d", $time,
                             m_red_out, m_green_out, m_blue_out, m_last_pixel, m_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WD_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        foreach (hist_m[i]) hist_m[i] = 0;
        foreach (thr_m[i]) thr_m[i] = 255;
        foreach (bcnt_m[i]) begin
            bcnt_m[i] = 0;
            bsum_m[i] = 0;
            lvl_m[i] = 0;
        end
        ld_idx = 0;
        rd_idx = 0;
        frm_len = 0;
        reading = 1'b0;
        cnt_reg = qcq_pkg::PIX_CNT_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_small_counts();
        test_count_change();
        test_abandon();
        test_backpressure();

        tx_idle_pct = 9;
        rx_idle_pct = 60;
        test_random(400);
        tx_idle_pct = 60;
        rx_idle_pct = 9;
        test_random(400);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(400);

        s_valid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
        $display("Covered %0d transfers in, %0d out, %0d completed frames, sizes 1 to 48,",
                 n_items, n_results, n_frames);
        $display("saturated and mid-frame count changes, abandoned readouts, long stall.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/qcq_pkg.sv
hw/rtl/qcq_ram.sv
hw/rtl/qcq_div.sv
hw/rtl/qcq_dp.sv
hw/rtl/qcq_ctrl.sv
hw/rtl/quartile_color_quantizer.sv
tb/sv/tb.sv
